@@ sv/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants
// Stack geometry, operation codes, error codes and the sequencer states.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned PtrW       = $clog2(StackDepth);
  localparam int unsigned DataW      = 32;
  localparam int unsigned FracW      = 16;
  localparam int unsigned FuncW      = 4;
  localparam int unsigned DepthW     = 4;
  localparam int unsigned ErrW       = 2;
  // multiplier digit width and number of digits
  localparam int unsigned DigW       = 4;
  localparam int unsigned MulSteps   = DataW / DigW;
  localparam int unsigned DivSteps   = DataW + FracW;
  localparam int unsigned CntW       = $clog2(DivSteps + 1);

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH = 4'd0,
    FUNC_ADD  = 4'd1,
    FUNC_SUB  = 4'd2,
    FUNC_MUL  = 4'd3,
    FUNC_DIV  = 4'd4,
    FUNC_NEG  = 4'd5,
    FUNC_SQR  = 4'd6,
    FUNC_SWAP = 4'd7,
    FUNC_DROP = 4'd8
  } func_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_DIV0  = 2'd2,
    ERR_FULL  = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_TOP,
    ST_RD_BELOW,
    ST_WAIT,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_WR1,
    ST_WR2,
    ST_RD_OUT,
    ST_RD_WAIT,
    ST_OUT
  } state_e;

endpackage

@@ sv/rpn_stream_if.sv @@
// ----------------------------------------------------------------------------
// rpn_stream_if: valid/ready channel
// Carries the request and result payloads of the stack calculator.
// ----------------------------------------------------------------------------
interface rpn_req_if;
  logic                                valid;
  logic                                ready;
  logic [rpn_pkg::FuncW-1:0]           func;
  logic signed [rpn_pkg::DataW-1:0]    push_value;
  modport source (output valid, func, push_value, input ready);
  modport sink   (input valid, func, push_value, output ready);
endinterface

interface rpn_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [rpn_pkg::DataW-1:0]    top_value;
  logic [rpn_pkg::DepthW-1:0]          depth;
  logic [rpn_pkg::ErrW-1:0]            error_code;
  logic                                saturated;
  modport source (output valid, top_value, depth, error_code, saturated, input ready);
  modport sink   (input valid, top_value, depth, error_code, saturated, output ready);
endinterface

@@ sv/rpn_ram.sv @@
// ----------------------------------------------------------------------------
// rpn_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or read the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ sv/rpn_alu.sv @@
// ----------------------------------------------------------------------------
// rpn_alu: serial Q16.16 multiply and divide
// Multiply retires one 4-bit digit per cycle, divide one quotient bit per
// cycle on magnitudes; signs, flooring of negative products and clipping come last.
// ----------------------------------------------------------------------------
module rpn_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_mul_i,
  input  logic                          start_div_i,
  input  logic signed [rpn_pkg::DataW-1:0] a_i,
  input  logic signed [rpn_pkg::DataW-1:0] b_i,
  output logic                          done_o,
  output logic [rpn_pkg::DataW-1:0]     res_o,
  output logic                          sat_o
);

  localparam int unsigned W  = rpn_pkg::DataW;
  localparam int unsigned F  = rpn_pkg::FracW;
  localparam int unsigned D  = rpn_pkg::DigW;
  localparam int unsigned NW = W + F;

  logic            busy_q, busy_d, is_div_q, is_div_d, neg_q, neg_d, fin_q, fin_d;
  logic [rpn_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    ma_q, ma_d;        // multiplicand magnitude / divisor
  logic [NW-1:0]   sh_q, sh_d;        // multiplier digits / dividend bits
  logic [2*W-1:0]  acc_q, acc_d;      // product or quotient
  logic [W-1:0]    rem_q, rem_d;      // partial remainder
  logic            rnz_q, rnz_d;      // nonzero discarded bits

  logic [W-1:0]    abs_a, abs_b;
  logic [W+D-1:0]  pp;
  logic [W:0]      trial;
  logic [W:0]      rsh;
  logic [2*W-F-1:0] mag;
  logic            round_up;
  logic [2*W-F:0]  mag_r;

  assign abs_a = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign abs_b = b_i[W-1] ? W'(-b_i) : W'(b_i);
  assign pp    = (W+D)'(ma_q) * (W+D)'(sh_q[D-1:0]);
  assign rsh   = {rem_q, sh_q[NW-1]};
  assign trial = rsh - {1'b0, ma_q};

  // advance the serial unit one step a cycle
  always_comb begin
    busy_d = busy_q; is_div_d = is_div_q; neg_d = neg_q; cnt_d = cnt_q;
    ma_d = ma_q; sh_d = sh_q; acc_d = acc_q; rem_d = rem_q; rnz_d = rnz_q;
    fin_d = 1'b0;
    if (start_mul_i || start_div_i) begin
      busy_d   = 1'b1;
      is_div_d = start_div_i;
      neg_d    = a_i[W-1] ^ b_i[W-1];
      cnt_d    = start_div_i ? rpn_pkg::CntW'(NW) : rpn_pkg::CntW'(rpn_pkg::MulSteps);
      ma_d     = start_div_i ? abs_b : abs_a;
      sh_d     = start_div_i ? {abs_a, F'(0)} : NW'(abs_b);
      acc_d    = '0;
      rem_d    = '0;
      rnz_d    = 1'b0;
    end else if (busy_q) begin
      if (is_div_q) begin
        sh_d = {sh_q[NW-2:0], 1'b0};
        if (!trial[W]) begin
          rem_d = trial[W-1:0];
          acc_d = {acc_q[2*W-2:0], 1'b1};
        end else begin
          rem_d = rsh[W-1:0];
          acc_d = {acc_q[2*W-2:0], 1'b0};
        end
      end else begin
        // add digit product at the top, shift right by one digit
        acc_d = {(W+D)'(acc_q[2*W-1:W]) + pp, acc_q[W-1:D]};
        rnz_d = rnz_q | (|acc_q[D-1:0]);
        sh_d  = NW'(sh_q[NW-1:D]);
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == rpn_pkg::CntW'(1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_div_q <= is_div_d; neg_q <= neg_d; cnt_q <= cnt_d; ma_q <= ma_d;
    sh_q <= sh_d; acc_q <= acc_d; rem_q <= rem_d; rnz_q <= rnz_d;
  end

  // sign, floor for negative products, clip to 32 bits
  always_comb begin
    if (is_div_q) begin
      mag      = acc_q[2*W-F-1:0];
      round_up = 1'b0;
    end else begin
      mag      = acc_q[2*W-1:F];
      round_up = neg_q && (rnz_q || (|acc_q[F-1:0]));
    end
    mag_r = (2*W-F+1)'(mag) + (2*W-F+1)'(round_up);
    sat_o = 1'b0;
    res_o = '0;
    if (neg_q) begin
      if (mag_r > (2*W-F+1)'(33'h080000000)) begin
        sat_o = 1'b1;
        res_o = {1'b1, {(W-1){1'b0}}};
      end else begin
        res_o = W'(-mag_r);
      end
    end else begin
      if (mag_r > (2*W-F+1)'(33'h07fffffff)) begin
        sat_o = 1'b1;
        res_o = {1'b0, {(W-1){1'b1}}};
      end else begin
        res_o = W'(mag_r);
      end
    end
  end

  assign done_o = fin_q;

endmodule

@@ sv/rpn_stack_calculator_top.sv @@
// ----------------------------------------------------------------------------
// rpn_stack_calculator_top: RPN evaluation stack on Q16.16 values
// Stack in a single-port RAM, a sequencer, and a serial multiply/divide unit.
// ----------------------------------------------------------------------------
// channel  dir  payload
// req_if   in   func, push_value
// rsp_if   out  top_value, depth, error_code, saturated
//
// Drop, unused codes and refused requests write no stack entry; push, add,
// subtract and negate write one, swap writes two, and multiply and square
// (8 multiplier digits) and divide (48 quotient bits) first run the serial
// unit and then write one. The single RAM port serializes reads and writes.
// After reset the base entry is written before any request is taken. A
// request is taken only once the previous result has left the output
// register; a stalled result holds.
module rpn_stack_calculator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  rpn_req_if.sink      req_if,
  rpn_rsp_if.source    rsp_if
);

  localparam int unsigned W = rpn_pkg::DataW;
  localparam int unsigned P = rpn_pkg::PtrW;

  rpn_pkg::state_e state_q, state_d;
  logic              init_q;
  logic [P-1:0]      cnt_q, cnt_d;
  logic [rpn_pkg::FuncW-1:0] func_q;
  logic [W-1:0]      pv_q, t_q, t_d, b_q, b_d, r1_q, r1_d;
  logic [rpn_pkg::ErrW-1:0] err_q, err_d;
  logic              sat_q, sat_d, wr2_q, wr2_d;
  logic [P-1:0]      a1_q, a1_d, a2_q, a2_d;
  logic [W-1:0]      r2_q, r2_d;
  logic              ovalid_q;
  logic [W-1:0]      otop_q;
  logic [P-1:0]      odep_q;
  logic [rpn_pkg::ErrW-1:0] oerr_q;
  logic              osat_q;

  logic              we;
  logic [P-1:0]      addr;
  logic [W-1:0]      wdata, rdata;
  logic              mul_go, div_go, alu_done, alu_sat;
  logic [W-1:0]      alu_res;
  logic [P-1:0]      below;
  logic [W:0]        sum;
  logic              take;

  assign below = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
  assign take  = req_if.valid && req_if.ready;
  assign req_if.ready = (state_q == rpn_pkg::ST_IDLE) && !ovalid_q && init_q;

  rpn_ram #(.Width(W), .Depth(rpn_pkg::StackDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  rpn_alu u_alu (
    .clk_i, .rst_ni, .start_mul_i(mul_go), .start_div_i(div_go),
    .a_i(t_q), .b_i((func_q == rpn_pkg::FUNC_SQR) ? t_q : b_q),
    .done_o(alu_done), .res_o(alu_res), .sat_o(alu_sat)
  );

  // next state and datapath registers
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; t_d = t_q; b_d = b_q;
    err_d = err_q; sat_d = sat_q; wr2_d = wr2_q;
    a1_d = a1_q; a2_d = a2_q; r1_d = r1_q; r2_d = r2_q;
    sum = '0;
    unique case (state_q)
      rpn_pkg::ST_IDLE:     if (take) state_d = rpn_pkg::ST_RD_TOP;
      rpn_pkg::ST_RD_TOP:   state_d = rpn_pkg::ST_RD_BELOW;
      rpn_pkg::ST_RD_BELOW: begin
        t_d = rdata;
        state_d = rpn_pkg::ST_WAIT;
      end
      rpn_pkg::ST_WAIT: begin
        b_d = rdata;
        state_d = rpn_pkg::ST_DECODE;
      end
      rpn_pkg::ST_DECODE: begin
        err_d = rpn_pkg::ERR_OK; sat_d = 1'b0; wr2_d = 1'b0;
        a1_d = below; a2_d = cnt_q;
        state_d = rpn_pkg::ST_RD_OUT;
        if (cnt_q == '0 && ((func_q >= 4'(rpn_pkg::FUNC_ADD) &&
            func_q <= 4'(rpn_pkg::FUNC_DIV)) || func_q == rpn_pkg::FUNC_SWAP ||
            func_q == rpn_pkg::FUNC_DROP)) begin
          err_d = rpn_pkg::ERR_EMPTY;
        end else begin
          case (func_q)
            rpn_pkg::FUNC_PUSH: begin
              if (cnt_q == P'(rpn_pkg::StackDepth - 1)) begin
                err_d = rpn_pkg::ERR_FULL;
              end else begin
                a1_d = cnt_q + 1'b1; r1_d = pv_q; cnt_d = cnt_q + 1'b1;
                state_d = rpn_pkg::ST_WR1;
              end
            end
            rpn_pkg::FUNC_ADD, rpn_pkg::FUNC_SUB: begin
              sum = (func_q == rpn_pkg::FUNC_ADD) ?
                    {t_q[W-1], t_q} + {b_q[W-1], b_q} : {t_q[W-1], t_q} - {b_q[W-1], b_q};
              sat_d = sum[W] ^ sum[W-1];
              r1_d  = sat_d ? (sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                            : sum[W-1:0];
              cnt_d = below; state_d = rpn_pkg::ST_WR1;
            end
            rpn_pkg::FUNC_MUL: state_d = rpn_pkg::ST_MUL;
            rpn_pkg::FUNC_DIV: begin
              if (b_q == '0) err_d = rpn_pkg::ERR_DIV0;
              else state_d = rpn_pkg::ST_DIV;
            end
            rpn_pkg::FUNC_NEG: begin
              sat_d = (t_q == {1'b1, {(W-1){1'b0}}});
              r1_d  = sat_d ? {1'b0, {(W-1){1'b1}}} : W'(-t_q);
              a1_d  = cnt_q; state_d = rpn_pkg::ST_WR1;
            end
            rpn_pkg::FUNC_SQR: begin
              a1_d = cnt_q; state_d = rpn_pkg::ST_MUL;
            end
            rpn_pkg::FUNC_SWAP: begin
              a1_d = cnt_q; r1_d = b_q; a2_d = below; r2_d = t_q; wr2_d = 1'b1;
              state_d = rpn_pkg::ST_WR1;
            end
            rpn_pkg::FUNC_DROP: cnt_d = below;
            default: ;
          endcase
        end
      end
      rpn_pkg::ST_MUL, rpn_pkg::ST_DIV: begin
        if (alu_done) begin
          r1_d = alu_res; sat_d = alu_sat;
          if (func_q != rpn_pkg::FUNC_SQR) cnt_d = below;
          state_d = rpn_pkg::ST_WR1;
        end
      end
      rpn_pkg::ST_WR1: state_d = wr2_q ? rpn_pkg::ST_WR2 : rpn_pkg::ST_RD_OUT;
      rpn_pkg::ST_WR2: state_d = rpn_pkg::ST_RD_OUT;
      rpn_pkg::ST_RD_OUT:  state_d = rpn_pkg::ST_RD_WAIT;
      rpn_pkg::ST_RD_WAIT: state_d = rpn_pkg::ST_OUT;
      rpn_pkg::ST_OUT:     state_d = rpn_pkg::ST_IDLE;
      default: state_d = rpn_pkg::ST_IDLE;
    endcase
  end

  // drive RAM port and unit starts
  always_comb begin
    we = 1'b0; addr = cnt_q; wdata = r1_q;
    mul_go = 1'b0; div_go = 1'b0;
    if (!init_q) begin
      we = 1'b1; addr = '0; wdata = '0;
    end else begin
      unique case (state_q)
        rpn_pkg::ST_RD_TOP:   addr = cnt_q;
        rpn_pkg::ST_RD_BELOW: addr = below;
        rpn_pkg::ST_DECODE: begin
          mul_go = (state_d == rpn_pkg::ST_MUL);
          div_go = (state_d == rpn_pkg::ST_DIV);
        end
        rpn_pkg::ST_WR1: begin
          we = 1'b1; addr = a1_q; wdata = r1_q;
        end
        rpn_pkg::ST_WR2: begin
          we = 1'b1; addr = a2_q; wdata = r2_q;
        end
        default: addr = cnt_q;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rpn_pkg::ST_IDLE;
      init_q   <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      init_q  <= 1'b1;
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == rpn_pkg::ST_OUT) ovalid_q <= 1'b1;
      else if (rsp_if.ready) ovalid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      func_q <= req_if.func;
      pv_q   <= req_if.push_value;
    end
    t_q <= t_d; b_q <= b_d; err_q <= err_d; sat_q <= sat_d; wr2_q <= wr2_d;
    a1_q <= a1_d; a2_q <= a2_d; r1_q <= r1_d; r2_q <= r2_d;
    if (state_q == rpn_pkg::ST_OUT) begin
      otop_q <= rdata;
      odep_q <= cnt_q;
      oerr_q <= err_q;
      osat_q <= (err_q == rpn_pkg::ERR_OK) && sat_q;
    end
  end

  assign rsp_if.valid      = ovalid_q;
  assign rsp_if.top_value  = otop_q;
  assign rsp_if.depth      = rpn_pkg::DepthW'(odep_q);
  assign rsp_if.error_code = oerr_q;
  assign rsp_if.saturated  = osat_q;

endmodule
